FILE: rtl/scqd_pkg.sv
// ----------------------------------------------------------------------------
// scqd_pkg
// Shared types and codes for the servo command queue dispatch unit.
// ----------------------------------------------------------------------------
package scqd_pkg;

    // Request codes carried in the slave-side tuser
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Fixed field widths
    localparam int ANGLE_W = 16;
    localparam int DUR_W   = 16;
    localparam int BUSY_W  = 16;
    localparam int CHAN_W  = 4;
    localparam int PART_IN_W = 4;
    localparam int ENTRY_W = ANGLE_W + DUR_W;

    // Result kind codes carried in the master-side tuser
    typedef enum logic [1:0] {
        RESP_ACK   = 2'd0,
        RESP_SWEEP = 2'd1,
        RESP_WAIT  = 2'd2
    } t_resp_kind;

    // Ring status of one channel
    typedef struct packed {
        logic full;
        logic empty;
    } t_chan_stat;

endpackage

FILE: rtl/scqd_ram.sv
// ----------------------------------------------------------------------------
// scqd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module scqd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/scqd_chan_ptr.sv
// ----------------------------------------------------------------------------
// scqd_chan_ptr
// Write/read pointer pair and full/empty status for one channel ring.
// ----------------------------------------------------------------------------
module scqd_chan_ptr #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_pop,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_wptr,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_rptr,
    output scqd_pkg::t_chan_stat           o_stat
);
    import scqd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [PTR_W-1:0] w_wnext, w_rnext;

    assign w_wnext = (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
    assign w_rnext = (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);

    always_comb begin
        n_wptr = i_push ? w_wnext : r_wptr;
        n_rptr = i_pop  ? w_rnext : r_rptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
        end
    end

    assign o_wptr       = r_wptr;
    assign o_rptr       = r_rptr;
    assign o_stat.full  = (w_wnext == r_rptr);
    assign o_stat.empty = (r_wptr == r_rptr);

endmodule

FILE: rtl/servo_command_queue_dispatch_unit.sv
// ----------------------------------------------------------------------------
// servo_command_queue_dispatch_unit
// Per-channel command rings with round-robin dispatch on planner ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes requests: tuser = 0 pushes {angle, duration} to the
//   ring of channel part + NUM_PARTS*side; tuser = 1 is a planner tick with
//   one busy bit per channel. Master stream returns one ack per push, and up
//   to two dispatches per tick (left channel first), tlast on the final one.
//   A tick that finds nothing to pop gives no transfer but still moves the
//   round-robin part pointer.
// Pipeline: a request passes the input register, then the RAM read /
//   result register, before its result leaves.
// Throughput: one request per cycle while results are taken; a tick that
//   pops both sides holds the result register for two transfers, so the
//   output port (one transfer per cycle) sets the rate.
// Reset: all ring pointers and the part pointer clear, wait marker goes to
//   all ones. The command store is not cleared; empty rings are never popped.
// Stall: a held result stays put, one more request waits in the input
//   register, then s_tready drops. Config writes only while idle.
// ----------------------------------------------------------------------------
module servo_command_queue_dispatch_unit #(
    parameter int NUM_PARTS   = 8,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: [0] side, [4:1] part, [20:5] angle, [36:21] duration,
    //        [52:37] busy_mask, [55:53] zero
    input  logic [55:0] i_s_tdata,
    // tuser: [0] req_type
    input  logic [0:0]  i_s_tuser,
    // result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: [0] accepted, [4:1] channel, [20:5] out_angle,
    //        [36:21] out_duration, [39:37] zero
    output logic [39:0] o_m_tdata,
    // tuser: [1:0] resp_kind
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tlast,
    // wait marker register
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);
    import scqd_pkg::*;

    localparam int NCH       = 2 * NUM_PARTS;
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int PART_W    = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
    localparam int CH_W      = $clog2(NCH);
    localparam int RAM_DEPTH = NUM_PARTS * QUEUE_DEPTH;
    localparam int AW        = $clog2(RAM_DEPTH);

    // ---------------- config ----------------
    logic [ANGLE_W-1:0] r_wait_marker;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_marker <= '1;
        end else if (i_cfg_wr_en) begin
            r_wait_marker <= i_cfg_wr_data;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic                 r_s1_valid;
    logic                 r_s1_req;
    logic                 r_s1_side;
    logic [PART_IN_W-1:0] r_s1_part;
    logic [ANGLE_W-1:0]   r_s1_angle;
    logic [DUR_W-1:0]     r_s1_dur;
    logic [BUSY_W-1:0]    r_s1_busy;

    logic w_s1_adv;
    logic w_s2_free;
    logic w_s_xfer;
    logic w_out_xfer;

    assign o_s_tready = !r_s1_valid || w_s1_adv;
    assign w_s_xfer   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_s1_req   <= i_s_tuser[0];
            r_s1_side  <= i_s_tdata[0];
            r_s1_part  <= i_s_tdata[4:1];
            r_s1_angle <= i_s_tdata[20:5];
            r_s1_dur   <= i_s_tdata[36:21];
            r_s1_busy  <= i_s_tdata[52:37];
        end
    end

    // ---------------- channel pointers ----------------
    logic [PTR_W-1:0] w_wptr [NCH];
    logic [PTR_W-1:0] w_rptr [NCH];
    t_chan_stat       w_stat [NCH];
    logic [NCH-1:0]   w_push_inc;
    logic [NCH-1:0]   w_pop_inc;

    for (genvar c = 0; c < NCH; c++) begin : g_chan
        scqd_chan_ptr #(
            .QUEUE_DEPTH(QUEUE_DEPTH)
        ) u_ptr (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_push  (w_push_inc[c]),
            .i_pop   (w_pop_inc[c]),
            .o_wptr  (w_wptr[c]),
            .o_rptr  (w_rptr[c]),
            .o_stat  (w_stat[c])
        );
    end

    // ---------------- stage 1 decisions ----------------
    logic [PART_W-1:0] r_scan, n_scan;
    logic              w_is_push, w_is_tick;
    logic              w_part_ok;
    logic [PART_W-1:0] w_part_idx;
    logic [CH_W-1:0]   w_push_ch;
    logic              w_push_ok;
    logic [CH_W-1:0]   w_lch, w_rch;
    logic              w_lpop, w_rpop;
    logic [AW-1:0]     w_wr_addr, w_lrd_addr, w_rrd_addr;

    assign w_is_push  = w_s1_adv && (r_s1_req == REQ_PUSH);
    assign w_is_tick  = w_s1_adv && (r_s1_req == REQ_TICK);
    assign w_part_ok  = ({1'b0, r_s1_part} < (PART_IN_W + 1)'(NUM_PARTS));
    assign w_part_idx = w_part_ok ? PART_W'(r_s1_part) : '0;
    assign w_push_ch  = CH_W'(w_part_idx) + (r_s1_side ? CH_W'(NUM_PARTS) : '0);
    assign w_push_ok  = w_part_ok && !w_stat[w_push_ch].full;

    // round-robin part: left channel p, right channel p + NUM_PARTS
    assign w_lch  = CH_W'(r_scan);
    assign w_rch  = CH_W'(r_scan) + CH_W'(NUM_PARTS);
    assign w_lpop = !r_s1_busy[CHAN_W'(r_scan)] && !w_stat[w_lch].empty;
    assign w_rpop = !r_s1_busy[CHAN_W'(r_scan) + CHAN_W'(NUM_PARTS)]
                    && !w_stat[w_rch].empty;

    always_comb begin
        w_push_inc = '0;
        w_pop_inc  = '0;
        if (w_is_push && w_push_ok) begin
            w_push_inc[w_push_ch] = 1'b1;
        end
        if (w_is_tick) begin
            w_pop_inc[w_lch] = w_lpop;
            w_pop_inc[w_rch] = w_rpop;
        end
    end

    always_comb begin
        n_scan = r_scan;
        if (w_is_tick) begin
            n_scan = (r_scan == PART_W'(NUM_PARTS - 1)) ? '0 : r_scan + PART_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
    end

    // ring slot address = part * depth + pointer
    assign w_wr_addr  = AW'(w_part_idx) * AW'(QUEUE_DEPTH) + AW'(w_wptr[w_push_ch]);
    assign w_lrd_addr = AW'(r_scan) * AW'(QUEUE_DEPTH) + AW'(w_rptr[w_lch]);
    assign w_rrd_addr = AW'(r_scan) * AW'(QUEUE_DEPTH) + AW'(w_rptr[w_rch]);

    // ---------------- command store, one RAM per side ----------------
    logic [ENTRY_W-1:0] w_wr_data;
    logic [ENTRY_W-1:0] w_lrd_data, w_rrd_data;

    assign w_wr_data = {r_s1_dur, r_s1_angle};

    scqd_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(RAM_DEPTH)
    ) u_ram_left (
        .i_clk     (i_clk),
        .i_wr_en   (w_is_push && w_push_ok && !r_s1_side),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_is_tick),
        .i_rd_addr (w_lrd_addr),
        .o_rd_data (w_lrd_data)
    );

    scqd_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(RAM_DEPTH)
    ) u_ram_right (
        .i_clk     (i_clk),
        .i_wr_en   (w_is_push && w_push_ok && r_s1_side),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_is_tick),
        .i_rd_addr (w_rrd_addr),
        .o_rd_data (w_rrd_data)
    );

    // ---------------- stage 2: result register ----------------
    // ack: push response pending; lpop/rpop: dispatches pending, left first
    logic              r_s2_ack, r_s2_lpop, r_s2_rpop;
    logic              r_s2_ok;
    logic [PART_W-1:0] r_s2_part;

    assign w_out_xfer = o_m_tvalid && i_m_tready;
    assign w_s2_free  = !o_m_tvalid || (w_out_xfer && o_m_tlast);
    assign w_s1_adv   = r_s1_valid && w_s2_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ack  <= 1'b0;
            r_s2_lpop <= 1'b0;
            r_s2_rpop <= 1'b0;
        end else if (w_s1_adv) begin
            r_s2_ack  <= w_is_push;
            r_s2_lpop <= w_is_tick && w_lpop;
            r_s2_rpop <= w_is_tick && w_rpop;
        end else if (w_out_xfer) begin
            if (r_s2_ack) begin
                r_s2_ack <= 1'b0;
            end else if (r_s2_lpop) begin
                r_s2_lpop <= 1'b0;
            end else begin
                r_s2_rpop <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s2_ok   <= w_push_ok;
            r_s2_part <= r_scan;
        end
    end

    // ---------------- result formatting ----------------
    logic [ENTRY_W-1:0] w_entry;
    logic [ANGLE_W-1:0] w_ent_angle;
    logic [DUR_W-1:0]   w_ent_dur;
    t_resp_kind         w_kind;
    logic               w_acc;
    logic [CHAN_W-1:0]  w_chan;
    logic [ANGLE_W-1:0] w_out_angle;
    logic [DUR_W-1:0]   w_out_dur;

    assign w_entry     = r_s2_lpop ? w_lrd_data : w_rrd_data;
    assign w_ent_angle = w_entry[ANGLE_W-1:0];
    assign w_ent_dur   = w_entry[ENTRY_W-1:ANGLE_W];

    always_comb begin
        w_kind      = RESP_ACK;
        w_acc       = 1'b0;
        w_chan      = '0;
        w_out_angle = '0;
        w_out_dur   = '0;
        if (r_s2_ack) begin
            w_acc = r_s2_ok;
        end else begin
            w_chan    = CHAN_W'(r_s2_part) + (r_s2_lpop ? '0 : CHAN_W'(NUM_PARTS));
            w_out_dur = w_ent_dur;
            if (w_ent_angle == r_wait_marker) begin
                w_kind = RESP_WAIT;
            end else begin
                w_kind      = RESP_SWEEP;
                w_out_angle = w_ent_angle;
            end
        end
    end

    assign o_m_tvalid = r_s2_ack || r_s2_lpop || r_s2_rpop;
    assign o_m_tlast  = r_s2_ack || (r_s2_lpop ^ r_s2_rpop);
    assign o_m_tuser  = w_kind;
    assign o_m_tdata  = {3'b000, w_out_dur, w_out_angle, w_chan, w_acc};

`ifndef SYNTH
    // a request that leaves results must show them on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv && (w_is_push || w_lpop || w_rpop) |=> o_m_tvalid)
        else $error("result register empty after loading a request");

    // a non-final result only while both sides of a tick are pending
    a_last_pairing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> r_s2_lpop && r_s2_rpop && !r_s2_ack)
        else $error("tlast low without a second dispatch pending");

    // round-robin pointer stays inside the part range
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_is_tick |=> (32'(r_scan) < NUM_PARTS))
        else $error("scan part pointer out of range");
`endif

endmodule
